// ===== sv/hgc_pkg.sv =====
//------------------------------------------------------------------------------
// hgc_pkg
// Shared widths, register indexes, status codes, decision windows and the
// divider request/response types of the hand gesture classifier.
//------------------------------------------------------------------------------
`default_nettype none

package hgc_pkg;

   // field widths
   localparam int HX_W       = 10;
   localparam int FC_W       = 3;
   localparam int FXS_W      = 13;
   localparam int FM_W       = 10;
   localparam int MARGIN_W   = 10;
   localparam int TMO_W      = 5;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   // default geometry
   localparam int RING_DEPTH_DEF = 32;
   localparam int LOOKBACK_DEF   = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATE_MARGIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STILL_MARGIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAN_MARGIN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SWIPE_TIMEOUT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATE_TIMEOUT = 3'd4;

   // register reset values
   localparam logic [MARGIN_W-1:0] ROTATE_MARGIN_RST  = 10'd50;
   localparam logic [MARGIN_W-1:0] STILL_MARGIN_RST   = 10'd30;
   localparam logic [MARGIN_W-1:0] PAN_MARGIN_RST     = 10'd70;
   localparam logic [TMO_W-1:0]    SWIPE_TIMEOUT_RST  = 5'd15;
   localparam logic [TMO_W-1:0]    ROTATE_TIMEOUT_RST = 5'd5;

   // status codes
   localparam logic [STATUS_W-1:0] ST_IDLE         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SWIPE_L      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SWIPE_R      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ROTATE_HOLD  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LEFT_MOTION  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_RIGHT_MOTION = 3'd5;

   // back value windows (exclusive bounds)
   localparam logic [HX_W-1:0] SWL_BACK_LO = 10'd300;
   localparam logic [HX_W-1:0] SWL_BACK_HI = 10'd320;
   localparam logic [HX_W-1:0] SWR_BACK_LO = 10'd0;
   localparam logic [HX_W-1:0] SWR_BACK_HI = 10'd20;
   localparam logic [HX_W-1:0] ROT_BACK_LO = 10'd120;
   localparam logic [HX_W-1:0] ROT_BACK_HI = 10'd200;

   // hand mean windows (exclusive bounds)
   localparam int MEAN_SWL_HI = 250;
   localparam int MEAN_SWR_LO = 70;
   localparam int MEAN_ROT_LO = 140;
   localparam int MEAN_ROT_HI = 180;

   typedef struct packed {
      logic             start;
      logic [FXS_W-1:0] dividend;
      logic [FC_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [FM_W-1:0] quotient;   // saturated
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== sv/hgc_div.sv =====
//------------------------------------------------------------------------------
// hgc_div
// Serial restoring divider for the finger mean: one quotient bit a cycle,
// result saturated to the finger mean width.
//------------------------------------------------------------------------------
`default_nettype none

module hgc_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hgc_pkg::div_req_type div_req,
   output hgc_pkg::div_rsp_type     div_rsp
);

   localparam int STEP_W = $clog2(hgc_pkg::FXS_W);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [hgc_pkg::FC_W-1:0]   rem_ff, rem_in;
   logic [hgc_pkg::FC_W-1:0]   dvs_ff, dvs_in;
   logic [hgc_pkg::FXS_W-1:0]  quo_ff, quo_in;   // dividend out, quotient in

   logic [hgc_pkg::FC_W:0]     trial;
   logic [hgc_pkg::FC_W:0]     diff;
   logic                       fits;

   assign trial = {rem_ff, quo_ff[hgc_pkg::FXS_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(hgc_pkg::FXS_W - 1);
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         quo_in = {quo_ff[hgc_pkg::FXS_W-2:0], fits};
         rem_in = fits ? diff[hgc_pkg::FC_W-1:0] : trial[hgc_pkg::FC_W-1:0];
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = (|quo_ff[hgc_pkg::FXS_W-1:hgc_pkg::FM_W])
                             ? {hgc_pkg::FM_W{1'b1}} : quo_ff[hgc_pkg::FM_W-1:0];

endmodule

`default_nettype wire

// ===== sv/hand_gesture_classifier.sv =====
//------------------------------------------------------------------------------
// hand_gesture_classifier
// Frame-by-frame gesture detector: swipes, rotations and pans from the hand
// centre history and the finger mean.
//------------------------------------------------------------------------------
// One request is one tracked frame and gives exactly one response (status code
// plus six gesture pulses). Frames are handled one at a time: the response is
// valid when the frame is written back; req_ready returns in that same cycle,
// so a new request is taken only after the last frame is written back. The
// finger mean (finger_x_sum / finger_count) is formed by a 13-step serial
// divider loaded on acceptance; S_DIV waits for it to finish, and S_FIN writes
// the frame back. The hand history lives in a RING_DEPTH-deep synchronous RAM:
// the value LOOKBACK frames back is read on acceptance, the new hand x written
// on completion. The RAM carries a valid flop per entry cleared by reset, so
// there is no clearing pass; the block takes requests straight after reset.
// The mean of the last LOOKBACK hand values is kept as a running sum and
// compared against scaled thresholds, so no divider is needed there. A
// finished response sits in an output register, so a new request is taken
// while it waits for rsp_ready; the write-back of that next frame, and with it
// req_ready, then holds off until the waiting response is taken.
// csr_ready is always high; registers should be written only while idle.
//------------------------------------------------------------------------------
`default_nettype none

module hand_gesture_classifier #(
   parameter int RING_DEPTH = hgc_pkg::RING_DEPTH_DEF,
   parameter int LOOKBACK   = hgc_pkg::LOOKBACK_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic [hgc_pkg::HX_W-1:0]       req_hand_x,
   input  wire logic [hgc_pkg::FC_W-1:0]       req_finger_count,
   input  wire logic [hgc_pkg::FXS_W-1:0]      req_finger_x_sum,
   // response channel
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic [hgc_pkg::STATUS_W-1:0]   rsp_status,
   output      logic                           rsp_swipe_left,
   output      logic                           rsp_swipe_right,
   output      logic                           rsp_rotate_left,
   output      logic                           rsp_rotate_right,
   output      logic                           rsp_pan_left,
   output      logic                           rsp_pan_right,
   // register write port
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [hgc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [hgc_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int AW  = $clog2(RING_DEPTH);
   localparam int SW  = AW + 2;                          // ring index sums
   localparam int WSW = $clog2(LOOKBACK * 1023 + 1);     // window sum
   localparam int CW  = hgc_pkg::FM_W + 2;               // margin compares

   // mean thresholds scaled by LOOKBACK: mean < k <=> sum < k*L,
   // mean > k <=> sum >= (k+1)*L
   localparam logic [WSW-1:0] SUM_SWL_HI = WSW'(hgc_pkg::MEAN_SWL_HI * LOOKBACK);
   localparam logic [WSW-1:0] SUM_SWR_LO = WSW'((hgc_pkg::MEAN_SWR_LO + 1) * LOOKBACK);
   localparam logic [WSW-1:0] SUM_ROT_LO = WSW'((hgc_pkg::MEAN_ROT_LO + 1) * LOOKBACK);
   localparam logic [WSW-1:0] SUM_ROT_HI = WSW'(hgc_pkg::MEAN_ROT_HI * LOOKBACK);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_FIN
   } ctl_state_type;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_SWIPE_L,
      MODE_SWIPE_R,
      MODE_ROTATE
   } mode_type;

   // --- ring index arithmetic ---------------------------------------------
   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0]            base,
                                              input logic [hgc_pkg::TMO_W-1:0] ofs);
      logic [SW-1:0] t;
      t = SW'(base) + SW'(ofs);
      if (t >= SW'(2 * RING_DEPTH)) begin
         t = t - SW'(2 * RING_DEPTH);
      end else if (t >= SW'(RING_DEPTH)) begin
         t = t - SW'(RING_DEPTH);
      end
      return t[AW-1:0];
   endfunction

   // --- registers ----------------------------------------------------------
   ctl_state_type                  state_ff, state_in;
   mode_type                       mode_ff, mode_in;
   logic [AW-1:0]                  wr_idx_ff;
   logic [AW-1:0]                  tmo_idx_ff, tmo_idx_in;
   logic [WSW-1:0]                 wsum_ff, wsum_in;
   logic [hgc_pkg::FM_W-1:0]       saved_fm_ff, saved_fm_in;
   logic [hgc_pkg::HX_W-1:0]       hx_ff;
   logic [hgc_pkg::FC_W-1:0]       fc_ff;

   logic [hgc_pkg::MARGIN_W-1:0]   rot_margin_ff, still_margin_ff, pan_margin_ff;
   logic [hgc_pkg::TMO_W-1:0]      swipe_tmo_ff, rot_tmo_ff;

   logic                           rsp_valid_ff;
   logic [hgc_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic                           sl_ff, sl_in, sr_ff, sr_in;
   logic                           rl_ff, rl_in, rr_ff, rr_in;
   logic                           pl_ff, pl_in, pr_ff, pr_in;

   // --- hand history RAM ---------------------------------------------------
   logic [hgc_pkg::HX_W-1:0]       ring_mem [RING_DEPTH];
   logic [RING_DEPTH-1:0]          ring_vld_ff;
   logic [hgc_pkg::HX_W-1:0]       ring_rd_ff;
   logic                           ring_rd_vld_ff;
   logic [AW-1:0]                  back_addr;
   logic [SW-1:0]                  back_sum;
   logic                           ring_re, commit;

   hgc_pkg::div_req_type           div_req;
   hgc_pkg::div_rsp_type           div_rsp;

   logic [hgc_pkg::HX_W-1:0]       back;
   logic [hgc_pkg::FM_W-1:0]       fm;
   logic                           swl_win, swr_win, rot_win;
   logic [CW-1:0]                  h, b, s, f, rm, st, pm;
   logic                           still, rot_l, rot_r, pan_l, pan_r;
   logic [AW-1:0]                  swipe_tmo_idx, rot_tmo_idx, wr_idx_next;

   // --- handshake ----------------------------------------------------------
   assign req_ready = (state_ff == S_IDLE);
   assign ring_re   = req_valid && req_ready;
   assign commit    = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;

   // slot LOOKBACK frames behind the write pointer
   assign back_sum  = SW'(wr_idx_ff) + SW'(RING_DEPTH - (LOOKBACK % RING_DEPTH));
   assign back_addr = (back_sum >= SW'(RING_DEPTH)) ? AW'(back_sum - SW'(RING_DEPTH))
                                                    : AW'(back_sum);

   assign wr_idx_next = (wr_idx_ff == AW'(RING_DEPTH - 1)) ? '0 : wr_idx_ff + 1'b1;

   // RAM: write on completion, registered read on acceptance
   always_ff @(posedge clock) begin
      if (commit) begin
         ring_mem[wr_idx_ff] <= hx_ff;
      end
      if (ring_re) begin
         ring_rd_ff     <= ring_mem[back_addr];
         ring_rd_vld_ff <= ring_vld_ff[back_addr];
      end
   end

   // never-written slots read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff <= '0;
      end else if (commit) begin
         ring_vld_ff[wr_idx_ff] <= 1'b1;
      end
   end

   // --- finger mean divider ------------------------------------------------
   assign div_req.start    = ring_re;
   assign div_req.dividend = req_finger_x_sum;
   assign div_req.divisor  = req_finger_count;

   hgc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // --- decision -----------------------------------------------------------
   assign back = ring_rd_vld_ff ? ring_rd_ff : '0;
   assign fm   = div_rsp.quotient;

   assign swl_win = (back > hgc_pkg::SWL_BACK_LO) && (back < hgc_pkg::SWL_BACK_HI)
                    && (wsum_ff < SUM_SWL_HI);
   assign swr_win = (back > hgc_pkg::SWR_BACK_LO) && (back < hgc_pkg::SWR_BACK_HI)
                    && (wsum_ff >= SUM_SWR_LO);
   assign rot_win = (back > hgc_pkg::ROT_BACK_LO) && (back < hgc_pkg::ROT_BACK_HI)
                    && (wsum_ff < SUM_ROT_HI) && (wsum_ff >= SUM_ROT_LO);

   assign h  = CW'(hx_ff);
   assign b  = CW'(back);
   assign s  = CW'(saved_fm_ff);
   assign f  = CW'(fm);
   assign rm = CW'(rot_margin_ff);
   assign st = CW'(still_margin_ff);
   assign pm = CW'(pan_margin_ff);

   // hand strictly within still_margin of the back value
   assign still = (h < b + st) && (h + st > b);
   assign rot_l = (s > f + rm) && still;
   assign rot_r = (s + rm < f) && still;
   assign pan_l = (s > f + pm) && (h + pm < b);
   assign pan_r = (s + pm < f) && (h > b + pm);

   assign swipe_tmo_idx = ring_add(wr_idx_ff, swipe_tmo_ff);
   assign rot_tmo_idx   = ring_add(wr_idx_ff, rot_tmo_ff);

   assign wsum_in = WSW'({1'b0, wsum_ff} + (WSW + 1)'(hx_ff) - (WSW + 1)'(back));

   always_comb begin
      mode_in     = mode_ff;
      tmo_idx_in  = tmo_idx_ff;
      saved_fm_in = saved_fm_ff;
      status_in   = hgc_pkg::ST_IDLE;
      sl_in       = 1'b0;
      sr_in       = 1'b0;
      rl_in       = 1'b0;
      rr_in       = 1'b0;
      pl_in       = 1'b0;
      pr_in       = 1'b0;
      case (mode_ff)
         MODE_ROTATE: begin
            if (fc_ff != '0) begin
               status_in = hgc_pkg::ST_ROTATE_HOLD;
               if (rot_l) begin
                  rl_in     = 1'b1;
                  status_in = hgc_pkg::ST_LEFT_MOTION;
               end else if (rot_r) begin
                  rr_in     = 1'b1;
                  status_in = hgc_pkg::ST_RIGHT_MOTION;
               end
               // pan wins over rotation in status
               if (pan_l) begin
                  pl_in     = 1'b1;
                  status_in = hgc_pkg::ST_LEFT_MOTION;
               end else if (pan_r) begin
                  pr_in     = 1'b1;
                  status_in = hgc_pkg::ST_RIGHT_MOTION;
               end
            end else begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_SWIPE_L, MODE_SWIPE_R: begin
            status_in = (mode_ff == MODE_SWIPE_L) ? hgc_pkg::ST_SWIPE_L
                                                  : hgc_pkg::ST_SWIPE_R;
            if (wr_idx_ff == tmo_idx_ff) begin
               mode_in = MODE_IDLE;
            end
            if (rot_win) begin
               tmo_idx_in = rot_tmo_idx;
               if (fc_ff != '0) begin
                  saved_fm_in = fm;
                  mode_in     = MODE_ROTATE;
               end
            end
         end
         default: begin
            if (swl_win) begin
               mode_in    = MODE_SWIPE_L;
               tmo_idx_in = swipe_tmo_idx;
               sl_in      = 1'b1;
            end else if (swr_win) begin
               mode_in    = MODE_SWIPE_R;
               tmo_idx_in = swipe_tmo_idx;
               sr_in      = 1'b1;
            end else if (rot_win) begin
               tmo_idx_in = rot_tmo_idx;
               if (fc_ff != '0) begin
                  saved_fm_in = fm;
                  mode_in     = MODE_ROTATE;
               end
            end
         end
      endcase
   end

   // --- sequencer ----------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (ring_re) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_IDLE;
         wr_idx_ff    <= '0;
         tmo_idx_ff   <= '0;
         wsum_ff      <= '0;
         saved_fm_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            mode_ff      <= mode_in;
            wr_idx_ff    <= wr_idx_next;
            tmo_idx_ff   <= tmo_idx_in;
            wsum_ff      <= wsum_in;
            saved_fm_ff  <= saved_fm_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (ring_re) begin
         hx_ff <= req_hand_x;
         fc_ff <= req_finger_count;
      end
      if (commit) begin
         status_ff <= status_in;
         sl_ff     <= sl_in;
         sr_ff     <= sr_in;
         rl_ff     <= rl_in;
         rr_ff     <= rr_in;
         pl_ff     <= pl_in;
         pr_ff     <= pr_in;
      end
   end

   // --- registers ----------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_margin_ff   <= hgc_pkg::ROTATE_MARGIN_RST;
         still_margin_ff <= hgc_pkg::STILL_MARGIN_RST;
         pan_margin_ff   <= hgc_pkg::PAN_MARGIN_RST;
         swipe_tmo_ff    <= hgc_pkg::SWIPE_TIMEOUT_RST;
         rot_tmo_ff      <= hgc_pkg::ROTATE_TIMEOUT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            hgc_pkg::CSR_ROTATE_MARGIN:  rot_margin_ff   <= csr_data;
            hgc_pkg::CSR_STILL_MARGIN:   still_margin_ff <= csr_data;
            hgc_pkg::CSR_PAN_MARGIN:     pan_margin_ff   <= csr_data;
            hgc_pkg::CSR_SWIPE_TIMEOUT:  swipe_tmo_ff    <= csr_data[hgc_pkg::TMO_W-1:0];
            hgc_pkg::CSR_ROTATE_TIMEOUT: rot_tmo_ff      <= csr_data[hgc_pkg::TMO_W-1:0];
            default: ;
         endcase
      end
   end

   // --- outputs ------------------------------------------------------------
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_swipe_left   = sl_ff;
   assign rsp_swipe_right  = sr_ff;
   assign rsp_rotate_left  = rl_ff;
   assign rsp_rotate_right = rr_ff;
   assign rsp_pan_left     = pl_ff;
   assign rsp_pan_right    = pr_ff;

   // --- checks -------------------------------------------------------------
   // at most one direction of gesture per frame
   a_one_gesture: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_swipe_left, rsp_swipe_right,
                              rsp_rotate_left | rsp_pan_left,
                              rsp_rotate_right | rsp_pan_right}))
      else $error("conflicting gesture pulses");

   // a swipe is flagged from idle, so status still reads idle
   a_swipe_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_swipe_left || rsp_swipe_right) |-> rsp_status == hgc_pkg::ST_IDLE)
      else $error("swipe pulse with non-idle status");

   // left rotation or pan always reports left motion
   a_left_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_rotate_left || rsp_pan_left)
         |-> rsp_status == hgc_pkg::ST_LEFT_MOTION)
      else $error("left event without left motion status");

   // one frame in flight: no request taken straight after another
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a frame is in flight");

endmodule

`default_nettype wire
